### hdl/sfms_pkg.sv
// Shared types and constants for the substring first-match search core.
// No dependencies; compile first.
`default_nettype none

package sfms_pkg;

    // Field widths of the item and result channels
    localparam int DATA_W   = 8;
    localparam int PIDX_W   = 7;
    localparam int CFG_W    = 8;
    localparam int RESOFF_W = 32;

    // Item function codes
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // Broadcast control to every match cell
    typedef struct packed {
        logic              shift;     // text byte advances the match vector
        logic              clear;     // end of search, drop all match bits
        logic [DATA_W-1:0] data_byte; // pattern byte or text byte
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/sfms_if.sv
// Valid/ready channel interfaces for the search core: item input and result output.
// Depends on sfms_pkg for field widths.
`default_nettype none

interface sfms_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [sfms_pkg::PIDX_W-1:0] pattern_index;
    logic [sfms_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, func, pattern_index, data_byte, last_byte,
                    input ready);
    modport sink (input valid, func, pattern_index, data_byte, last_byte,
                  output ready);
endinterface

interface sfms_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [sfms_pkg::RESOFF_W-1:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink (input valid, found, match_offset, output ready);
endinterface

`default_nettype wire

### hdl/sfms_cell.sv
// One pattern position of the shift-and match chain: pattern byte and prefix-match bit.
// Depends on sfms_pkg for the control struct.
`default_nettype none

module sfms_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sfms_pkg::t_cell_ctl         i_ctl,
    input  wire logic                        i_wr,
    input  wire logic                        i_prev_match,
    output logic                             o_match,
    output logic                             o_shift_match
);
    import sfms_pkg::*;

    logic [DATA_W-1:0] r_pat;
    logic              r_match;
    logic              n_match;

    // Load the pattern byte for this position
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pat <= i_ctl.data_byte;
        end
    end

    // Extend the neighbor's prefix match by this byte
    assign o_shift_match = i_prev_match && (r_pat == i_ctl.data_byte);

    always_comb begin
        n_match = r_match;
        if (i_ctl.clear) begin
            n_match = 1'b0;
        end else if (i_ctl.shift) begin
            n_match = o_shift_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;

endmodule

`default_nettype wire

### hdl/substring_first_match_search_core.sv
// Substring first-match search core: top level with match chain and result buffer.
// Depends on sfms_pkg, sfms_in_if / sfms_out_if and sfms_cell.
`default_nettype none

// Pattern items (func 0) load one byte into the cell at pattern_index; text
// items (func 1) stream through a row of MAX_PATTERN shift-and cells, one
// item per clock while ready. The first full match of pattern_length bytes
// gives a result with found = 1 and the zero-based start offset; a search that
// ends on last_byte without a match gives found = 0, offset 0. Bytes after a
// match are dropped until last_byte. Results are registered; the cell compare
// plus the select of the bit at pattern_length-1 set the clock period. A
// two-entry result buffer keeps the input open while one result waits. The
// user must write pattern_length only while the core is idle; the core does
// not enforce it. No clearing pass is needed after reset.
module substring_first_match_search_core #(
    parameter int MAX_PATTERN = 128,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [sfms_pkg::CFG_W-1:0] i_cfg_data,
    sfms_in_if.sink                        i_item,
    sfms_out_if.source                     o_result
);
    import sfms_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // Configuration derived at write time
    logic [LEN_W-1:0]       cfg_len;
    logic [LEN_W-1:0]       cfg_len_m1;
    logic                   r_len_zero;
    logic [IDX_W-1:0]       r_last_idx;
    logic [OFFSET_BITS-1:0] r_back;

    // Search state
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_done;

    // Result buffer
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [RESOFF_W-1:0]    r_out_offset;
    logic                   r_skid_valid;
    logic                   r_skid_found;
    logic [RESOFF_W-1:0]    r_skid_offset;

    logic                   acc;
    logic                   pat_wr;
    logic                   is_text;
    logic                   active;
    logic                   hit;
    logic                   res_valid;
    logic [OFFSET_BITS-1:0] offset;
    logic [63:0]            offset_wide;
    logic [RESOFF_W-1:0]    res_offset;
    logic                   out_take;
    t_cell_ctl              ctl;

    logic [MAX_PATTERN-1:0] match_vec;
    logic [MAX_PATTERN-1:0] shift_vec;
    logic [MAX_PATTERN-1:0] wr_sel;

    assign o_cfg_ready = 1'b1;

    // Clamp the written length to the chain size
    always_comb begin
        if (32'(i_cfg_data) > MAX_PATTERN) begin
            cfg_len = LEN_W'(MAX_PATTERN);
        end else begin
            cfg_len = LEN_W'(i_cfg_data);
        end
        cfg_len_m1 = cfg_len - LEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_zero <= 1'b1;
            r_last_idx <= '0;
            r_back     <= '0;
        end else if (i_cfg_valid) begin
            r_len_zero <= (cfg_len == '0);
            r_last_idx <= cfg_len_m1[IDX_W-1:0];
            r_back     <= OFFSET_BITS'(cfg_len_m1);
        end
    end

    // Decode the accepted item
    assign i_item.ready = !r_skid_valid;
    assign acc          = i_item.valid && i_item.ready;
    assign pat_wr       = acc && (i_item.func == FUNC_PATTERN);
    assign is_text      = acc && (i_item.func == FUNC_TEXT);
    assign active       = is_text && !r_done;

    assign ctl.shift     = active && !r_len_zero;
    assign ctl.clear     = is_text && i_item.last_byte;
    assign ctl.data_byte = i_item.data_byte;

    // Row of match cells, each fed by its left neighbor
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            logic prev;
            if (k == 0) begin : g_head
                assign prev = 1'b1;
            end else begin : g_link
                assign prev = match_vec[k-1];
            end
            if (k < (1 << PIDX_W)) begin : g_wr
                assign wr_sel[k] = pat_wr && (i_item.pattern_index == PIDX_W'(k));
            end else begin : g_nowr
                assign wr_sel[k] = 1'b0;
            end
            sfms_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_wr          (wr_sel[k]),
                .i_prev_match  (prev),
                .o_match       (match_vec[k]),
                .o_shift_match (shift_vec[k])
            );
        end
    endgenerate

    // Detect the first full match and form the result
    assign hit       = active && (r_len_zero || shift_vec[r_last_idx]);
    assign res_valid = hit || (active && i_item.last_byte);

    always_comb begin
        if (r_len_zero) begin
            offset = '0;
        end else begin
            offset = r_pos - r_back;
        end
        offset_wide = 64'(offset);
        res_offset  = hit ? offset_wide[RESOFF_W-1:0] : '0;
    end

    // Advance the text position and track a reported match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= 1'b0;
        end else if (ctl.clear) begin
            r_pos  <= '0;
            r_done <= 1'b0;
        end else if (active) begin
            if (r_pos != POS_MAX) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end
            if (hit) begin
                r_done <= 1'b1;
            end
        end
    end

    // Output register with skid entry
    assign out_take = r_out_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !out_take) begin
            if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !out_take) begin
            if (res_valid) begin
                r_skid_found  <= hit;
                r_skid_offset <= res_offset;
            end
        end else if (r_skid_valid) begin
            r_out_found  <= r_skid_found;
            r_out_offset <= r_skid_offset;
        end else if (res_valid) begin
            r_out_found  <= hit;
            r_out_offset <= res_offset;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out_found;
    assign o_result.match_offset = r_out_offset;

endmodule

`default_nettype wire

### bench/sfms_search_checker.sv
`timescale 1ns / 100ps
// Checker for the substring first-match search core: predicts every result from the
// item, config and result channels and compares. Depends on sfms_pkg, sfms_in_if, sfms_out_if.

module sfms_search_checker #(
    parameter int MAX_PATTERN = 128,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [sfms_pkg::CFG_W-1:0] i_cfg_data,
    sfms_in_if                              i_item,
    sfms_out_if                             i_result,
    output logic [31:0]                     o_fail_count,
    output logic [31:0]                     o_pending
);
    import sfms_pkg::*;

    typedef struct packed {
        logic                found;
        logic [RESOFF_W-1:0] offset;
    } t_search_result;

    // Shadow state of the search engine
    logic [DATA_W-1:0]      pat_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] prefix_bits;
    logic [OFFSET_BITS-1:0] text_pos;
    logic                   hit_reported;
    logic [CFG_W-1:0]       pat_len;
    t_search_result         expected_hits [$];
    int                     mismatch_count;

    initial begin
        for (int i = 0; i < MAX_PATTERN; i++) pat_mem[i] = '0;
        prefix_bits    = '0;
        text_pos       = '0;
        hit_reported   = 1'b0;
        pat_len        = '0;
        mismatch_count = 0;
        o_fail_count   = '0;
        o_pending      = '0;
    end

    // Drop the match bits and rewind the offset at the end of a search
    task automatic close_search();
        prefix_bits  = '0;
        text_pos     = '0;
        hit_reported = 1'b0;
    endtask

    // Advance the shadow engine by one item and queue the result it causes
    task automatic search_step(input logic func, input logic [PIDX_W-1:0] idx,
                               input logic [DATA_W-1:0] b, input logic last);
        int                     eff_len;
        logic                   hit;
        logic [OFFSET_BITS-1:0] start;
        t_search_result         res;

        if (func == FUNC_PATTERN) begin
            if (idx < MAX_PATTERN) pat_mem[idx] = b;
            return;
        end
        if (hit_reported) begin
            if (last) close_search();
            return;
        end

        eff_len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        hit     = 1'b0;
        start   = text_pos;
        if (eff_len == 0) begin
            hit   = 1'b1;
            start = '0;
        end else begin
            // Shift-and update, top bit first so each cell sees the old neighbor
            for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
                prefix_bits[k] = ((k == 0) ? 1'b1 : prefix_bits[k-1]) && (pat_mem[k] == b);
            end
            if (prefix_bits[eff_len-1]) begin
                hit   = 1'b1;
                start = text_pos - OFFSET_BITS'(eff_len - 1);
            end
        end

        // Saturate the offset counter at its top value
        if (text_pos != '1) text_pos = text_pos + 1'b1;

        if (hit) begin
            res.found  = 1'b1;
            res.offset = RESOFF_W'(start);
            expected_hits.push_back(res);
            if (last) close_search();
            else hit_reported = 1'b1;
        end else if (last) begin
            res.found  = 1'b0;
            res.offset = '0;
            expected_hits.push_back(res);
            close_search();
        end
    endtask

    always @(posedge i_clk) begin
        t_search_result want;

        if (!i_rst_n) begin
            close_search();
            pat_len = '0;
            expected_hits.delete();
        end else begin
            // Compare the accepted result against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result found=%0d offset=%0d", $time,
                             i_result.found, i_result.match_offset);
                    mismatch_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (i_result.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0d actual %0d", $time,
                                 want.found, i_result.found);
                        mismatch_count++;
                    end
                    if (i_result.match_offset !== want.offset) begin
                        $display("%0t: match_offset mismatch, expected %0d actual %0d",
                                 $time, want.offset, i_result.match_offset);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) pat_len = i_cfg_data;
            if (i_item.valid && i_item.ready) begin
                search_step(i_item.func, i_item.pattern_index, i_item.data_byte,
                            i_item.last_byte);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_hits.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Top of the search core bench: clock, reset, item/config stimulus, random result stalls
// and the verdict. Depends on sfms_pkg, the channel interfaces, the core and sfms_search_checker.

module tb;
    import sfms_pkg::*;

    localparam int MAX_PATTERN    = 128;
    localparam int OFFSET_BITS    = 32;
    localparam int ITEM_TARGET    = 1900;
    localparam int QUIET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic [31:0]      fail_count;
    logic [31:0]      pending;

    sfms_in_if  item_ch ();
    sfms_out_if result_ch ();

    substring_first_match_search_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    sfms_search_checker #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    logic [DATA_W-1:0] patt [MAX_PATTERN];
    int                n_items;
    bit                calm;
    int                quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int item_gap();
        if (calm || $urandom_range(0, 99) < 60) return 0;
        return idle_len();
    endfunction

    // Byte from a small alphabet so that matches are common; zero means any byte
    function automatic logic [DATA_W-1:0] rand_sym(int alpha);
        if (alpha == 0) return DATA_W'($urandom_range(0, 255));
        case ($urandom_range(0, alpha - 1))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h5A;
            default: return 8'hA5;
        endcase
    endfunction

    // Present one item after an optional gap and hold it until accepted
    task automatic put_item(input logic func, input logic [PIDX_W-1:0] idx,
                            input logic [DATA_W-1:0] b, input logic last);
        int gap;

        gap = item_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.func          = func;
        item_ch.pattern_index = idx;
        item_ch.data_byte     = b;
        item_ch.last_byte     = last;
        item_ch.valid         = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        n_items++;
    endtask

    task automatic load_byte(input int idx, input logic [DATA_W-1:0] b);
        put_item(FUNC_PATTERN, PIDX_W'(idx), b, 1'($urandom_range(0, 1)));
        patt[idx] = b;
    endtask

    task automatic text_byte(input logic [DATA_W-1:0] b, input logic last);
        put_item(FUNC_TEXT, PIDX_W'($urandom_range(0, MAX_PATTERN - 1)), b, last);
    endtask

    // Drop valid, wait for every result, then let the pipeline drain
    task automatic wait_quiet();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length(input int len);
        wait_quiet();
        cfg_data  = CFG_W'(len);
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // One search: random text, mostly with the pattern planted, sometimes spoiled
    task automatic run_search(input int len, input int alpha);
        int               n;
        int               at;
        int               spoil;
        bit               plant;
        logic [DATA_W-1:0] b;

        n     = $urandom_range(1, len + 12);
        plant = (len > 0) && (n >= len) && ($urandom_range(0, 3) != 0);
        at    = plant ? $urandom_range(0, n - len) : n;
        spoil = (plant && $urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int j = 0; j < n; j++) begin
            // Rare pattern rewrite in the middle of a search
            if ($urandom_range(0, 59) == 0)
                load_byte($urandom_range(0, MAX_PATTERN - 1), rand_sym(alpha));
            if (j >= at && j < at + len) begin
                b = patt[j - at];
                if (j - at == spoil) b = ~b;
            end else begin
                b = rand_sym(alpha);
            end
            text_byte(b, j == n - 1);
        end
    endtask

    // New length, full pattern reload, then a few searches
    task automatic run_phase(input int phase);
        int cfg_val;
        int eff;
        int alpha;
        int start;
        int searches;
        int r;

        r = $urandom_range(0, 99);
        if (phase == 0) cfg_val = MAX_PATTERN;
        else if (phase == 1) cfg_val = 255;
        else if (r < 50) cfg_val = $urandom_range(0, 6);
        else if (r < 80) cfg_val = $urandom_range(7, 24);
        else if (r < 90) cfg_val = $urandom_range(25, MAX_PATTERN - 1);
        else if (r < 95) cfg_val = MAX_PATTERN;
        else cfg_val = $urandom_range(MAX_PATTERN + 1, 255);
        calm = ($urandom_range(0, 3) == 0);
        set_length(cfg_val);

        eff   = (cfg_val > MAX_PATTERN) ? MAX_PATTERN : cfg_val;
        alpha = $urandom_range(0, 4);
        if (eff > 0) begin
            start = $urandom_range(0, eff - 1);
            for (int i = 0; i < eff; i++) load_byte((start + i) % eff, rand_sym(alpha));
        end
        searches = (eff > 32) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        repeat (searches) run_search(eff, alpha);
    endtask

    // Result side: random stalls unless the phase runs calm
    initial begin
        int stall;

        stall           = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                stall--;
            end else begin
                result_ch.ready = 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) stall = idle_len();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;

        i_rst_n               = 1'b0;
        cfg_valid             = 1'b0;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.func          = FUNC_PATTERN;
        item_ch.pattern_index = '0;
        item_ch.data_byte     = '0;
        item_ch.last_byte     = 1'b0;
        n_items               = 0;
        calm                  = 1'b0;
        quiet_cycles          = 0;
        phase                 = 0;
        for (int i = 0; i < MAX_PATTERN; i++) patt[i] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero length: first byte matches at offset 0, the rest up to last_byte is dropped, the next byte matches anew
        set_length(0);
        text_byte(8'h00, 1'b0);
        text_byte(8'hFF, 1'b0);
        text_byte(8'h12, 1'b1);
        text_byte(8'hAB, 1'b1);

        // One-byte pattern, match on the last byte of the text
        set_length(1);
        load_byte(MAX_PATTERN - 1, 8'hFF);
        load_byte(0, 8'hFF);
        text_byte(8'h00, 1'b0);
        text_byte(8'hFF, 1'b1);

        // Overlapping prefix, bytes after a match, short text, plain miss
        set_length(3);
        load_byte(0, 8'h61);
        load_byte(1, 8'h61);
        load_byte(2, 8'h62);
        text_byte(8'h61, 1'b0);
        text_byte(8'h61, 1'b0);
        text_byte(8'h61, 1'b0);
        text_byte(8'h62, 1'b0);
        text_byte(8'h78, 1'b1);
        text_byte(8'h61, 1'b0);
        text_byte(8'h61, 1'b1);
        text_byte(8'h62, 1'b1);

        // Random phases, the longest and an oversized length first
        while (n_items < ITEM_TARGET) begin
            run_phase(phase);
            phase++;
        end

        calm = 1'b0;
        wait_quiet();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
